>>> rtl/fragment_context_table_defines.svh
// assertion macros for the fragment context table checker
// needs clk and rst_n in the scope where a macro is used
`ifndef FRAGMENT_CONTEXT_TABLE_DEFINES_SVH
`define FRAGMENT_CONTEXT_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fct check failed");

// next-cycle implication, disabled while in reset
`define FCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fct check failed");

`endif

>>> rtl/fct_pkg.sv
// shared types and constants for the fragment context table
// no dependencies
package fct_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int CMD_W   = 2;
    localparam int ID_W    = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int OUTC_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FREE  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

    // what the slot walk has found so far
    typedef struct packed {
        logic has_hit;
        logic has_free;
        logic has_old;
    } scan_flags_t;

endpackage

>>> rtl/fct_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fct_scan.sv
// shared compare unit: one slot per cycle while en is high, tracks first match,
// highest free slot and oldest valid slot; uses fct_pkg
module fct_scan #(
    parameter int IDX_W = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        en,
    input  logic [IDX_W-1:0]            idx,
    input  logic                        valid,
    input  logic [fct_pkg::ID_W-1:0]    ident,
    input  logic [fct_pkg::STAMP_W-1:0] stamp,
    input  logic [fct_pkg::ID_W-1:0]    key,
    output fct_pkg::scan_flags_t        flags,
    output logic [IDX_W-1:0]            hit_idx,
    output logic [IDX_W-1:0]            free_idx,
    output logic [IDX_W-1:0]            old_idx
);

    fct_pkg::scan_flags_t        flags_reg, flags_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]            old_idx_reg, old_idx_next;
    logic [fct_pkg::STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic                        is_match;
    logic                        is_older;

    assign is_match = valid && (ident == key);
    // strict compare keeps the lowest index on equal stamps
    assign is_older = valid && (!flags_reg.has_old || (stamp < old_stamp_reg));

    always_comb
    begin
        flags_next     = flags_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        if (clear)
        begin
            flags_next   = '0;
            old_idx_next = '0;
        end
        else if (en)
        begin
            if (is_match && !flags_reg.has_hit)
            begin
                flags_next.has_hit = 1'b1;
                hit_idx_next       = idx;
            end
            // last free slot seen is the highest numbered one
            if (!valid)
            begin
                flags_next.has_free = 1'b1;
                free_idx_next       = idx;
            end
            if (is_older)
            begin
                flags_next.has_old = 1'b1;
                old_idx_next       = idx;
                old_stamp_next     = stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
    end

    assign flags    = flags_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;
    assign old_idx  = old_idx_reg;

endmodule

>>> rtl/fragment_context_table.sv
// fragment context table top level: sequencer, slot valid bits, result register
// uses fct_pkg, fct_ram, fct_scan
//
//   channel   signals                          direction
//   in        in_valid in_stall command        into block
//             entry_id current_time
//   out       out_valid out_stall slot found   out of block
//             outcome
//
// each transaction walks all ENTRIES slots through the slot ram, one read a cycle
// into one compare unit, then passes the drain and done states before the next accept
// in_stall is high from the cycle after an accept until the sequencer is idle again
// the result register lets a new transaction in while the last result is unclaimed
// out_stall only holds the final step when the previous result is still waiting
// reset frees every slot at once through the valid bits
module fragment_context_table #(
    parameter int ENTRIES = fct_pkg::DEFAULT_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fct_pkg::CMD_W-1:0]   command,
    input  logic [fct_pkg::ID_W-1:0]    entry_id,
    input  logic [fct_pkg::STAMP_W-1:0] current_time,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fct_pkg::SLOT_W-1:0]  slot,
    output logic                        found,
    output logic [fct_pkg::OUTC_W-1:0]  outcome
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int RAM_W = fct_pkg::ID_W + fct_pkg::STAMP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [IDX_W-1:0]            cnt_reg, cnt_next;
    logic                        cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [fct_pkg::CMD_W-1:0]   cmd_reg;
    logic [fct_pkg::ID_W-1:0]    key_reg;
    logic [fct_pkg::STAMP_W-1:0] time_reg;
    logic [ENTRIES-1:0]          valid_reg, valid_next;
    logic                        out_valid_reg, out_valid_next;
    logic [fct_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                        found_reg, found_next;
    logic [fct_pkg::OUTC_W-1:0]  outcome_reg, outcome_next;

    logic                        in_accept;
    logic                        finish;
    logic                        wr_en;
    logic [IDX_W-1:0]            pick;
    logic [IDX_W+3:0]            pick_ext;
    logic [RAM_W-1:0]            rd_data;
    fct_pkg::scan_flags_t        flags;
    logic [IDX_W-1:0]            hit_idx;
    logic [IDX_W-1:0]            free_idx;
    logic [IDX_W-1:0]            old_idx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign finish    = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    fct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pick),
        .wr_data ({key_reg, time_reg}),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    fct_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (in_accept),
        .en       (cmp_en_reg),
        .idx      (cmp_idx_reg),
        .valid    (valid_reg[cmp_idx_reg]),
        .ident    (rd_data[RAM_W-1 -: fct_pkg::ID_W]),
        .stamp    (rd_data[fct_pkg::STAMP_W-1:0]),
        .key      (key_reg),
        .flags    (flags),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .old_idx  (old_idx)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmp_en_next  = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cmp_en_next  = 1'b1;
                cmp_idx_next = cnt_reg;
                cnt_next     = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // final decision once the walk is complete
    always_comb
    begin
        pick         = '0;
        wr_en        = 1'b0;
        valid_next   = valid_reg;
        found_next   = 1'b0;
        outcome_next = fct_pkg::OUTC_HIT;
        case (cmd_reg)
            fct_pkg::CMD_ADD:
            begin
                if (flags.has_hit)
                begin
                    pick       = hit_idx;
                    found_next = 1'b1;
                end
                else if (flags.has_free)
                begin
                    pick         = free_idx;
                    wr_en        = finish;
                    outcome_next = fct_pkg::OUTC_FREE;
                end
                else
                begin
                    pick         = old_idx;
                    wr_en        = finish;
                    outcome_next = fct_pkg::OUTC_EVICT;
                end
                if (wr_en)
                begin
                    valid_next[pick] = 1'b1;
                end
            end
            fct_pkg::CMD_DEL:
            begin
                found_next = flags.has_hit;
                if (finish && flags.has_hit)
                begin
                    valid_next[hit_idx] = 1'b0;
                end
            end
            fct_pkg::CMD_SEARCH:
            begin
                found_next = flags.has_hit;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
        // slot carries the low bits of the index, zero unless add
        pick_ext  = {4'b0000, pick};
        slot_next = (cmd_reg == fct_pkg::CMD_ADD) ? pick_ext[3:0] : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_en_reg    <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_en_reg    <= cmp_en_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        cmp_idx_reg <= cmp_idx_next;
        if (in_accept)
        begin
            cmd_reg  <= command;
            key_reg  <= entry_id;
            time_reg <= current_time;
        end
        if (finish)
        begin
            slot_reg    <= slot_next;
            found_reg   <= found_next;
            outcome_reg <= outcome_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign found     = found_reg;
    assign outcome   = outcome_reg;

endmodule

>>> rtl/fct_checker.sv
// port-level checks for the fragment context table, bound to the top level
// uses fct_pkg and fragment_context_table_defines.svh
`include "fragment_context_table_defines.svh"

module fct_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [fct_pkg::SLOT_W-1:0]  slot,
    input logic                        found,
    input logic [fct_pkg::OUTC_W-1:0]  outcome
);

    // a held result keeps its payload
    `FCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(slot) && $stable(found) && $stable(outcome))

    // the table is busy walking its slots right after a transaction is taken
    `FCT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a free-slot or eviction outcome never comes with a match
    `FCT_ASSERT_NOW(a_alloc_no_match, out_valid && (outcome == fct_pkg::OUTC_FREE || outcome == fct_pkg::OUTC_EVICT), !found)

    // only add reports a slot, so a miss with hit outcome means slot zero
    `FCT_ASSERT_NOW(a_slot_zero, out_valid && !found && outcome == fct_pkg::OUTC_HIT, slot == '0)

endmodule

bind fragment_context_table fct_checker u_fct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot      (slot),
    .found     (found),
    .outcome   (outcome)
);

>>> dv/tb_fragment_context_table.sv
// testbench for fragment_context_table: directed and random add, delete and search traffic
// checked against an in-bench slot table predictor; needs fct_pkg and the block rtl
`timescale 1ns / 100ps

module tb_fragment_context_table;
    import fct_pkg::*;

    localparam int N_SLOTS = DEFAULT_ENTRIES;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_idx;
        logic              found;
        logic [OUTC_W-1:0] outc;
    } lookup_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command = CMD_SEARCH;
    logic [ID_W-1:0]      entry_id = '0;
    logic [STAMP_W-1:0]   current_time = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SLOT_W-1:0]    slot;
    logic                 found;
    logic [OUTC_W-1:0]    outcome;

    // predicted slot table
    logic                 model_valid [N_SLOTS];
    logic [ID_W-1:0]      model_ident [N_SLOTS];
    logic [STAMP_W-1:0]   model_stamp [N_SLOTS];

    lookup_result_t       pending_results [$];
    logic [ID_W-1:0]      id_pool [POOL_SIZE];
    logic [STAMP_W-1:0]   clock_now = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int n_hits = 0;
    int n_claims = 0;
    int n_evictions = 0;
    int n_freed = 0;
    int n_search_hits = 0;

    fragment_context_table #(
        .ENTRIES(N_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .entry_id(entry_id),
        .current_time(current_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot(slot),
        .found(found),
        .outcome(outcome)
    );

    always #6 clk = ~clk;

    // works out the result of one transaction and updates the predicted table
    function automatic lookup_result_t predict_lookup(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [STAMP_W-1:0] now);
        lookup_result_t     r;
        int                 hit;
        int                 free_idx;
        int                 old_idx;
        int                 pick;
        logic [STAMP_W-1:0] old_stamp;
        r = '0;
        hit = -1;
        free_idx = -1;
        old_idx = -1;
        old_stamp = '0;
        for (int i = N_SLOTS - 1; i >= 0; i--)
        begin
            if (model_valid[i] && model_ident[i] == id)
                hit = i;
        end
        case (cmd)
            CMD_ADD:
            begin
                if (hit >= 0)
                begin
                    r.slot_idx = SLOT_W'(hit);
                    r.found = 1'b1;
                    r.outc = OUTC_HIT;
                    n_hits++;
                end
                else
                begin
                    // highest free slot wins, else oldest stamp with lowest index
                    for (int i = 0; i < N_SLOTS; i++)
                    begin
                        if (!model_valid[i])
                            free_idx = i;
                        else if (old_idx < 0 || model_stamp[i] < old_stamp)
                        begin
                            old_idx = i;
                            old_stamp = model_stamp[i];
                        end
                    end
                    if (free_idx >= 0)
                    begin
                        pick = free_idx;
                        r.outc = OUTC_FREE;
                        n_claims++;
                    end
                    else
                    begin
                        pick = old_idx;
                        r.outc = OUTC_EVICT;
                        n_evictions++;
                    end
                    model_valid[pick] = 1'b1;
                    model_ident[pick] = id;
                    model_stamp[pick] = now;
                    r.slot_idx = SLOT_W'(pick);
                end
            end
            CMD_DEL:
            begin
                if (hit >= 0)
                begin
                    model_valid[hit] = 1'b0;
                    r.found = 1'b1;
                    n_freed++;
                end
            end
            CMD_SEARCH:
            begin
                r.found = (hit >= 0);
                if (hit >= 0)
                    n_search_hits++;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string what, input lookup_result_t want,
                                input lookup_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR %s at %0t: expected slot %0d found %0b outcome %0d,",
                     what, $time, want.slot_idx, want.found, want.outc,
                     " got slot %0d found %0b outcome %0d",
                     got.slot_idx, got.found, got.outc);
    endtask

    // one transaction on the input channel, with random idle cycles in front
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [STAMP_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        entry_id <= id;
        current_time <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_lookup(cmd, id, now));
        items_sent++;
    endtask

    // receiver stalls and the result check share one clocked process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin : check_port
            lookup_result_t want;
            lookup_result_t got;
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                got = {slot, found, outcome};
                results_checked++;
                if (pending_results.size() == 0)
                    note_failure("result with nothing pending", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.slot_idx !== want.slot_idx || got.found !== want.found ||
                        got.outc !== want.outc)
                        note_failure("result mismatch", want, got);
                end
            end
        end
    end

    task automatic test_add_hit_delete();
        send_item(CMD_SEARCH, 16'h1234, 32'h0);
        send_item(CMD_DEL, 16'h1234, 32'h0);
        send_item(CMD_ADD, 16'h0000, 32'h0000_0000);
        send_item(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        // a hit must leave the stored stamp alone
        send_item(CMD_ADD, 16'h0000, 32'h0000_0005);
        send_item(CMD_SEARCH, 16'hFFFF, 32'h0);
        send_item(CMD_DEL, 16'hFFFF, 32'h0);
        send_item(CMD_DEL, 16'h0000, 32'h0);
    endtask

    task automatic test_unused_command();
        send_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_eviction_ties();
        for (int i = 0; i < N_SLOTS; i++)
            send_item(CMD_ADD, 16'h8000 + 16'(i), 32'hFFFF_FFFF);
        // all stamps at the top value, lowest index goes
        send_item(CMD_ADD, 16'h7FFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int sender_pct, input int receiver_pct,
                                   input int count);
        int                 n;
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                cmd = CMD_ADD;
            else if (pick < 68)
                cmd = CMD_DEL;
            else if (pick < 93)
                cmd = CMD_SEARCH;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(99) < 78)
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = ID_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 70)
                clock_now = clock_now + $urandom_range(3);
            else if (pick < 95)
                clock_now = $urandom;
            else
                clock_now = 32'hFFFF_FFFF;
            send_item(cmd, id, clock_now);
            n++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
        begin
            model_valid[i] = 1'b0;
            model_ident[i] = '0;
            model_stamp[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 71;
        test_add_hit_delete();
        test_unused_command();
        test_eviction_ties();
        test_random_mix(10, 71, 380);
        test_random_mix(71, 10, 380);
        test_random_mix(0, 0, 380);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (N_SLOTS + 8) @(posedge clk);

        $display("%0d transactions sent, %0d results checked:", items_sent, results_checked,
                 " %0d add hits, %0d free claims, %0d evictions",
                 n_hits, n_claims, n_evictions);
        $display("%0d deletes freed a slot, %0d searches hit, %0d failures",
                 n_freed, n_search_hits, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
